@@ hdl/e2g_pkg.sv @@
// shared constants, types and the cordic arctangent table of the ecef to geodetic block
package e2g_pkg;

   localparam int MAX_ITERATIONS = 16;
   localparam int IT_W = $clog2(MAX_ITERATIONS);
   localparam int CORDIC_STEPS = 62;

   localparam int COORD_W = 48;
   localparam int LAT_W = 62;
   localparam int LON_W = 63;
   localparam int HEIGHT_W = 48;
   localparam int AXIS_W = 47;
   localparam int ECC_W = 62;
   localparam int CSR_DATA_W = 62;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_SEMI_MAJOR = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_ECC = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_ECC = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_POLAR_RADIUS = 3'd3;

   localparam logic [AXIS_W-1:0] SEMI_MAJOR_RESET = 47'd417997586432;
   localparam logic [ECC_W-1:0] FIRST_ECC_RESET = 62'd30872378602579225;
   localparam logic [ECC_W-1:0] SECOND_ECC_RESET = 62'd31080442896463499;
   localparam logic [AXIS_W-1:0] POLAR_RADIUS_RESET = 47'd419403767860;

   localparam logic signed [63:0] PI_Q60 = 64'sd3622009729038561421;
   localparam logic signed [63:0] HALF_PI_Q60 = 64'sd1811004864519280711;
   localparam logic [63:0] QUARTER_PI_Q60 = 64'd905502432259640355;
   localparam logic [63:0] TOL_DIVISOR = 64'd10000000000;
   localparam logic [63:0] NORM_LIMIT = 64'd1 << 58;

   typedef logic [CORDIC_STEPS-1:0][63:0] atan_table_type;

   // atan(2^-i): series with truncated terms in 2^-64, rounded to 2^-60
   function automatic atan_table_type make_atan_table();
      atan_table_type tab;
      logic [63:0] sum;
      logic [63:0] term;
      int e;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         sum = '0;
         for (int k = 0; k < 64; k++) begin
            e = 64 - i * (2 * k + 1);
            if (i != 0 && e >= 1) begin
               term = (64'd1 << e) / 64'(2 * k + 1);
               if (k % 2 == 1) begin
                  sum = sum - term;
               end else begin
                  sum = sum + term;
               end
            end
         end
         if (i == 0) begin
            tab[i] = QUARTER_PI_Q60;
         end else begin
            tab[i] = (sum + 64'd8) >> 4;
         end
      end
      return tab;
   endfunction

   localparam atan_table_type ATAN_TABLE = make_atan_table();

endpackage

@@ hdl/ecef_to_geodetic_top.sv @@
// top level of the ecef to geodetic converter: sequencer with shared multiply, root, divide and cordic
//
//  channel | ports                               | handshake
//  --------+-------------------------------------+---------------------------------
//  input   | req_pos_x, req_pos_y, req_pos_z     | taken when start high, busy low
//  result  | rsp_latitude .. rsp_not_converged   | one-cycle strobe rsp_valid
//  config  | csr_we, csr_index, csr_wdata        | written at every edge with csr_we
//
// an on-axis item answers in the next cycle and leaves busy low
// any other item runs its latitude passes and the cordic normalize shifts on the
//   shared units: the 64-step shift-subtract root and divide and the 62-step cordic,
//   all run one step a cycle
// busy stays high from the accepted item until its result strobe
// synchronous active-high reset restores the ellipsoid registers and idles the sequencer
// the result strobe cannot be held off, so the block never stalls on its output
module ecef_to_geodetic_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [e2g_pkg::COORD_W-1:0]   req_pos_x,
   input  logic signed [e2g_pkg::COORD_W-1:0]   req_pos_y,
   input  logic signed [e2g_pkg::COORD_W-1:0]   req_pos_z,
   output logic                                 rsp_valid,
   output logic signed [e2g_pkg::LAT_W-1:0]     rsp_latitude,
   output logic signed [e2g_pkg::LON_W-1:0]     rsp_longitude,
   output logic signed [e2g_pkg::HEIGHT_W-1:0]  rsp_height,
   output logic                                 rsp_on_axis,
   output logic                                 rsp_not_converged,
   input  logic                                 csr_we,
   input  logic [e2g_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [e2g_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import e2g_pkg::*;

   // sequencer codes: shared units first, then the steps of the conversion
   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_MUL   = 5'd1;
   localparam logic [4:0] ST_SQRT  = 5'd2;
   localparam logic [4:0] ST_DIV   = 5'd3;
   localparam logic [4:0] ST_CNORM = 5'd4;
   localparam logic [4:0] ST_CROT  = 5'd5;
   localparam logic [4:0] ST_R2Y   = 5'd6;
   localparam logic [4:0] ST_RSQ   = 5'd7;
   localparam logic [4:0] ST_LON   = 5'd8;
   localparam logic [4:0] ST_LONF  = 5'd9;
   localparam logic [4:0] ST_RK    = 5'd10;
   localparam logic [4:0] ST_KR2   = 5'd11;
   localparam logic [4:0] ST_TOL   = 5'd12;
   localparam logic [4:0] ST_IT0   = 5'd13;
   localparam logic [4:0] ST_ITM   = 5'd14;
   localparam logic [4:0] ST_IT1   = 5'd15;
   localparam logic [4:0] ST_IT2   = 5'd16;
   localparam logic [4:0] ST_IT3   = 5'd17;
   localparam logic [4:0] ST_IT4   = 5'd18;
   localparam logic [4:0] ST_LAT   = 5'd19;
   localparam logic [4:0] ST_S0    = 5'd20;
   localparam logic [4:0] ST_S1    = 5'd21;
   localparam logic [4:0] ST_S2    = 5'd22;
   localparam logic [4:0] ST_S3    = 5'd23;
   localparam logic [4:0] ST_S4    = 5'd24;
   localparam logic [4:0] ST_S5    = 5'd25;
   localparam logic [4:0] ST_S6    = 5'd26;
   localparam logic [4:0] ST_FIN   = 5'd27;

   localparam logic [5:0] LAST_STEP = 6'd63;
   localparam logic [5:0] LAST_ROT = 6'(CORDIC_STEPS - 1);
   localparam logic [5:0] LAST_PART = 6'd3;
   localparam logic [IT_W-1:0] LAST_IT = IT_W'(MAX_ITERATIONS - 1);

   // ellipsoid registers
   logic [AXIS_W-1:0] semi_major_ff;
   logic [ECC_W-1:0]  first_ecc_ff;
   logic [ECC_W-1:0]  second_ecc_ff;
   logic [AXIS_W-1:0] polar_radius_ff;

   // sequencer
   logic [4:0] state_ff, state_in;
   logic [4:0] ret_ff, ret_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [IT_W-1:0] it_ff, it_in;

   // item and intermediate values
   logic signed [COORD_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [COORD_W-1:0] ax_ff, ax_in, ay_ff, ay_in;
   logic [95:0]  r2_ff, r2_in;
   logic [63:0]  r_ff, r_in;
   logic [63:0]  ce_ff, ce_in;
   logic [127:0] kr2_ff, kr2_in;
   logic [63:0]  tol_ff, tol_in;
   logic [63:0]  s_ff, s_in;
   logic signed [63:0] w_ff, w_in;
   logic signed [63:0] lon_ff, lon_in;
   logic signed [63:0] lat_ff, lat_in;
   logic conv_ff, conv_in;

   // shared unit registers
   logic [63:0]  op_a_ff, op_a_in, op_b_ff, op_b_in;
   logic [127:0] op_n_ff, op_n_in;
   logic [127:0] acc_ff, acc_in;
   logic [66:0]  rem_ff, rem_in;
   logic [63:0]  res_ff, res_in;
   logic [63:0]  dv_ff, dv_in;
   logic signed [63:0] vz_ff, vz_in;

   // result registers
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [LAT_W-1:0] lat_out_ff, lat_out_in;
   logic signed [LON_W-1:0] lon_out_ff, lon_out_in;
   logic signed [HEIGHT_W-1:0] h_out_ff, h_out_in;
   logic axis_out_ff, axis_out_in;
   logic nconv_out_ff, nconv_out_in;

   // helpers
   logic [COORD_W-1:0] req_ax, req_ay;
   logic [63:0]  aw, acc_q62, term;
   logic signed [63:0] z64, ang, ang_lon, wn, wdiff;
   logic [63:0]  dw;
   logic [31:0]  mul_a_half, mul_b_half;
   logic [63:0]  pp;
   logic [6:0]   mul_sh;
   logic [66:0]  sq_sh, sq_trial;
   logic [64:0]  dv_sh;
   logic signed [63:0] vx, vy, sh_x, sh_y, atan_step;
   logic [127:0] r2_acc;
   logic [63:0]  n_minus_s, s_minus_n;
   logic signed [HEIGHT_W-1:0] h_val;

   assign req_ax = req_pos_x[COORD_W-1] ? COORD_W'(-req_pos_x) : COORD_W'(req_pos_x);
   assign req_ay = req_pos_y[COORD_W-1] ? COORD_W'(-req_pos_y) : COORD_W'(req_pos_y);

   assign z64 = 64'(z_ff);
   assign aw = w_ff[63] ? 64'd0 - 64'(w_ff) : 64'(w_ff);
   assign acc_q62 = acc_ff[125:62];
   assign r2_acc = {32'd0, r2_ff} + acc_ff;
   assign term = res_ff;

   // 64x64 multiply as four 32x32 partial products
   assign mul_a_half = cnt_ff[1] ? op_a_ff[63:32] : op_a_ff[31:0];
   assign mul_b_half = cnt_ff[0] ? op_b_ff[63:32] : op_b_ff[31:0];
   assign pp = 64'(mul_a_half) * 64'(mul_b_half);
   assign mul_sh = {cnt_ff[1] & cnt_ff[0], cnt_ff[1] ^ cnt_ff[0], 5'd0};

   // restoring square root, two radicand bits a step
   assign sq_sh = {rem_ff[64:0], op_n_ff[127:126]};
   assign sq_trial = {1'b0, res_ff, 2'b01};

   // restoring divide, one quotient bit a step
   assign dv_sh = {rem_ff[63:0], op_n_ff[63]};

   // cordic rotation step
   assign vx = $signed(op_a_ff);
   assign vy = $signed(op_b_ff);
   assign sh_x = vx >>> cnt_ff;
   assign sh_y = vy >>> cnt_ff;
   assign atan_step = $signed(ATAN_TABLE[cnt_ff]);

   // cordic angle clamped to the first quadrant
   always_comb begin
      if (vz_ff < 0) begin
         ang = '0;
      end else if (vz_ff > HALF_PI_Q60) begin
         ang = HALF_PI_Q60;
      end else begin
         ang = vz_ff;
      end
   end

   assign ang_lon = x_ff[COORD_W-1] ? PI_Q60 - ang : ang;

   // next estimate of w = r*tan(B) and its change
   assign wn = w_ff[63] ? z64 - $signed(term) : z64 + $signed(term);
   assign wdiff = wn - w_ff;
   assign dw = wdiff[63] ? 64'd0 - 64'(wdiff) : 64'(wdiff);

   // height = S - N, saturated to the field
   assign n_minus_s = res_ff - s_ff;
   assign s_minus_n = s_ff - res_ff;
   always_comb begin
      if (res_ff > s_ff) begin
         if (n_minus_s > (64'd1 << 47)) begin
            h_val = {1'b1, 47'd0};
         end else begin
            h_val = HEIGHT_W'(64'd0 - n_minus_s);
         end
      end else begin
         if (s_minus_n > 64'((64'd1 << 47) - 64'd1)) begin
            h_val = {1'b0, {47{1'b1}}};
         end else begin
            h_val = HEIGHT_W'(s_minus_n);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      cnt_in = cnt_ff;
      it_in = it_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      ax_in = ax_ff;
      ay_in = ay_ff;
      r2_in = r2_ff;
      r_in = r_ff;
      ce_in = ce_ff;
      kr2_in = kr2_ff;
      tol_in = tol_ff;
      s_in = s_ff;
      w_in = w_ff;
      lon_in = lon_ff;
      lat_in = lat_ff;
      conv_in = conv_ff;
      op_a_in = op_a_ff;
      op_b_in = op_b_ff;
      op_n_in = op_n_ff;
      acc_in = acc_ff;
      rem_in = rem_ff;
      res_in = res_ff;
      dv_in = dv_ff;
      vz_in = vz_ff;
      rsp_valid_in = 1'b0;
      lat_out_in = lat_out_ff;
      lon_out_in = lon_out_ff;
      h_out_in = h_out_ff;
      axis_out_in = axis_out_ff;
      nconv_out_in = nconv_out_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               x_in = req_pos_x;
               y_in = req_pos_y;
               z_in = req_pos_z;
               ax_in = req_ax;
               ay_in = req_ay;
               if (req_pos_x == '0 && req_pos_y == '0) begin
                  // on the polar axis: answer at once with zeros
                  rsp_valid_in = 1'b1;
                  lat_out_in = '0;
                  lon_out_in = '0;
                  h_out_in = '0;
                  axis_out_in = 1'b1;
                  nconv_out_in = 1'b0;
               end else begin
                  op_a_in = 64'(req_ax);
                  op_b_in = 64'(req_ax);
                  acc_in = '0;
                  ret_in = ST_R2Y;
                  state_in = ST_MUL;
               end
            end
         end

         ST_MUL: begin
            acc_in = acc_ff + ({64'd0, pp} << mul_sh);
            if (cnt_ff == LAST_PART) begin
               cnt_in = '0;
               state_in = ret_ff;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end

         ST_SQRT: begin
            op_n_in = op_n_ff << 2;
            if (sq_sh >= sq_trial) begin
               rem_in = sq_sh - sq_trial;
               res_in = {res_ff[62:0], 1'b1};
            end else begin
               rem_in = sq_sh;
               res_in = {res_ff[62:0], 1'b0};
            end
            if (cnt_ff == LAST_STEP) begin
               cnt_in = '0;
               state_in = ret_ff;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end

         ST_DIV: begin
            if (cnt_ff == '0 && (dv_ff == '0 || rem_ff[63:0] >= dv_ff)) begin
               // quotient does not fit: saturate
               res_in = '1;
               state_in = ret_ff;
            end else begin
               op_n_in = op_n_ff << 1;
               if (dv_sh >= {1'b0, dv_ff}) begin
                  rem_in = {3'd0, 64'(dv_sh - {1'b0, dv_ff})};
                  res_in = {res_ff[62:0], 1'b1};
               end else begin
                  rem_in = {3'd0, dv_sh[63:0]};
                  res_in = {res_ff[62:0], 1'b0};
               end
               if (cnt_ff == LAST_STEP) begin
                  cnt_in = '0;
                  state_in = ret_ff;
               end else begin
                  cnt_in = cnt_ff + 6'd1;
               end
            end
         end

         ST_CNORM: begin
            if (op_b_ff == '0) begin
               vz_in = '0;
               state_in = ret_ff;
            end else if (op_a_ff == '0) begin
               vz_in = HALF_PI_Q60;
               state_in = ret_ff;
            end else if ((op_a_ff | op_b_ff) < NORM_LIMIT) begin
               op_a_in = op_a_ff << 1;
               op_b_in = op_b_ff << 1;
            end else begin
               vz_in = '0;
               state_in = ST_CROT;
            end
         end

         ST_CROT: begin
            if (!vy[63]) begin
               op_a_in = 64'(vx + sh_y);
               op_b_in = 64'(vy - sh_x);
               vz_in = vz_ff + atan_step;
            end else begin
               op_a_in = 64'(vx - sh_y);
               op_b_in = 64'(vy + sh_x);
               vz_in = vz_ff - atan_step;
            end
            if (cnt_ff == LAST_ROT) begin
               cnt_in = '0;
               state_in = ret_ff;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end

         ST_R2Y: begin
            r2_in = acc_ff[95:0];
            op_a_in = 64'(ay_ff);
            op_b_in = 64'(ay_ff);
            acc_in = '0;
            ret_in = ST_RSQ;
            state_in = ST_MUL;
         end

         ST_RSQ: begin
            r2_in = r2_acc[95:0];
            op_n_in = r2_acc;
            rem_in = '0;
            res_in = '0;
            ret_in = ST_LON;
            state_in = ST_SQRT;
         end

         ST_LON: begin
            r_in = res_ff;
            if (x_ff == '0) begin
               lon_in = (y_ff > 0) ? HALF_PI_Q60 : -HALF_PI_Q60;
               op_a_in = 64'(polar_radius_ff);
               op_b_in = 64'(first_ecc_ff);
               acc_in = '0;
               ret_in = ST_RK;
               state_in = ST_MUL;
            end else begin
               op_a_in = 64'(ax_ff);
               op_b_in = 64'(ay_ff);
               ret_in = ST_LONF;
               state_in = ST_CNORM;
            end
         end

         ST_LONF: begin
            lon_in = y_ff[COORD_W-1] ? -ang_lon : ang_lon;
            op_a_in = 64'(polar_radius_ff);
            op_b_in = 64'(first_ecc_ff);
            acc_in = '0;
            ret_in = ST_RK;
            state_in = ST_MUL;
         end

         ST_RK: begin
            ce_in = acc_q62;
            op_a_in = r_ff;
            op_b_in = 64'(second_ecc_ff);
            acc_in = '0;
            ret_in = ST_KR2;
            state_in = ST_MUL;
         end

         ST_KR2: begin
            // k*r^2 = r * (r + r*e2^2)
            op_a_in = r_ff;
            op_b_in = r_ff + acc_q62;
            acc_in = '0;
            ret_in = ST_TOL;
            state_in = ST_MUL;
         end

         ST_TOL: begin
            kr2_in = acc_ff;
            op_n_in = {64'd0, r_ff - 64'd1};
            rem_in = '0;
            dv_in = TOL_DIVISOR;
            ret_in = ST_IT0;
            state_in = ST_DIV;
         end

         ST_IT0: begin
            tol_in = res_ff;
            w_in = z64;
            it_in = '0;
            state_in = ST_ITM;
         end

         ST_ITM: begin
            op_a_in = aw;
            op_b_in = aw;
            acc_in = '0;
            ret_in = ST_IT1;
            state_in = ST_MUL;
         end

         ST_IT1: begin
            op_n_in = kr2_ff + acc_ff;
            rem_in = '0;
            res_in = '0;
            ret_in = ST_IT2;
            state_in = ST_SQRT;
         end

         ST_IT2: begin
            dv_in = res_ff;
            op_a_in = ce_ff;
            op_b_in = aw;
            acc_in = '0;
            ret_in = ST_IT3;
            state_in = ST_MUL;
         end

         ST_IT3: begin
            op_n_in = acc_ff;
            rem_in = {3'd0, acc_ff[127:64]};
            ret_in = ST_IT4;
            state_in = ST_DIV;
         end

         ST_IT4: begin
            w_in = wn;
            if (dw <= tol_ff) begin
               conv_in = 1'b1;
               state_in = ST_LAT;
            end else if (it_ff == LAST_IT) begin
               conv_in = 1'b0;
               state_in = ST_LAT;
            end else begin
               it_in = it_ff + IT_W'(1);
               state_in = ST_ITM;
            end
         end

         ST_LAT: begin
            op_a_in = r_ff;
            op_b_in = aw;
            ret_in = ST_S0;
            state_in = ST_CNORM;
         end

         ST_S0: begin
            lat_in = w_ff[63] ? -ang : ang;
            op_a_in = aw;
            op_b_in = aw;
            acc_in = '0;
            ret_in = ST_S1;
            state_in = ST_MUL;
         end

         ST_S1: begin
            op_n_in = r2_acc;
            rem_in = '0;
            res_in = '0;
            ret_in = ST_S2;
            state_in = ST_SQRT;
         end

         ST_S2: begin
            s_in = res_ff;
            op_a_in = aw;
            op_b_in = 64'(first_ecc_ff);
            acc_in = '0;
            ret_in = ST_S3;
            state_in = ST_MUL;
         end

         ST_S3: begin
            // aw * (1 - e1^2) * aw
            op_a_in = aw;
            op_b_in = aw - acc_q62;
            acc_in = '0;
            ret_in = ST_S4;
            state_in = ST_MUL;
         end

         ST_S4: begin
            op_n_in = r2_acc;
            rem_in = '0;
            res_in = '0;
            ret_in = ST_S5;
            state_in = ST_SQRT;
         end

         ST_S5: begin
            dv_in = res_ff;
            op_a_in = 64'(semi_major_ff);
            op_b_in = s_ff;
            acc_in = '0;
            ret_in = ST_S6;
            state_in = ST_MUL;
         end

         ST_S6: begin
            op_n_in = acc_ff;
            rem_in = {3'd0, acc_ff[127:64]};
            ret_in = ST_FIN;
            state_in = ST_DIV;
         end

         ST_FIN: begin
            rsp_valid_in = 1'b1;
            lat_out_in = LAT_W'(lat_ff);
            lon_out_in = LON_W'(lon_ff);
            h_out_in = h_val;
            axis_out_in = 1'b0;
            nconv_out_in = !conv_ff;
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff <= ST_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         semi_major_ff <= SEMI_MAJOR_RESET;
         first_ecc_ff <= FIRST_ECC_RESET;
         second_ecc_ff <= SECOND_ECC_RESET;
         polar_radius_ff <= POLAR_RADIUS_RESET;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_SEMI_MAJOR:   semi_major_ff <= csr_wdata[AXIS_W-1:0];
               CSR_FIRST_ECC:    first_ecc_ff <= csr_wdata[ECC_W-1:0];
               CSR_SECOND_ECC:   second_ecc_ff <= csr_wdata[ECC_W-1:0];
               CSR_POLAR_RADIUS: polar_radius_ff <= csr_wdata[AXIS_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      it_ff <= it_in;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      ax_ff <= ax_in;
      ay_ff <= ay_in;
      r2_ff <= r2_in;
      r_ff <= r_in;
      ce_ff <= ce_in;
      kr2_ff <= kr2_in;
      tol_ff <= tol_in;
      s_ff <= s_in;
      w_ff <= w_in;
      lon_ff <= lon_in;
      lat_ff <= lat_in;
      conv_ff <= conv_in;
      op_a_ff <= op_a_in;
      op_b_ff <= op_b_in;
      op_n_ff <= op_n_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
      dv_ff <= dv_in;
      vz_ff <= vz_in;
      lat_out_ff <= lat_out_in;
      lon_out_ff <= lon_out_in;
      h_out_ff <= h_out_in;
      axis_out_ff <= axis_out_in;
      nconv_out_ff <= nconv_out_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_latitude = lat_out_ff;
   assign rsp_longitude = lon_out_ff;
   assign rsp_height = h_out_ff;
   assign rsp_on_axis = axis_out_ff;
   assign rsp_not_converged = nconv_out_ff;

endmodule

@@ hdl/e2g_checker.sv @@
// port-level checks of the ecef to geodetic converter and their binding
module e2g_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 start,
   input logic                                 busy,
   input logic signed [e2g_pkg::COORD_W-1:0]   req_pos_x,
   input logic signed [e2g_pkg::COORD_W-1:0]   req_pos_y,
   input logic                                 rsp_valid,
   input logic signed [e2g_pkg::LAT_W-1:0]     rsp_latitude,
   input logic signed [e2g_pkg::LON_W-1:0]     rsp_longitude,
   input logic signed [e2g_pkg::HEIGHT_W-1:0]  rsp_height,
   input logic                                 rsp_on_axis,
   input logic                                 rsp_not_converged
);
   import e2g_pkg::*;

   logic signed [63:0] lat_wide;
   assign lat_wide = 64'(rsp_latitude);

   // an off-axis item keeps the block busy
   a_off_axis_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_pos_x != '0 || req_pos_y != '0) |=> busy)
      else $error("off-axis item did not raise busy");

   // a full result closes a busy period
   a_result_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_on_axis |-> $past(busy))
      else $error("result without a busy period");

   // an on-axis result follows its item directly and is all zero
   a_axis_prompt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_on_axis |-> $past(start && !busy))
      else $error("on-axis result not right after its item");

   a_axis_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_on_axis |-> rsp_latitude == '0 && rsp_longitude == '0
         && rsp_height == '0 && !rsp_not_converged)
      else $error("on-axis result not zero");

   // latitude stays within plus or minus pi/2
   a_lat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> lat_wide <= HALF_PI_Q60 && lat_wide >= -HALF_PI_Q60)
      else $error("latitude out of range");

endmodule

bind ecef_to_geodetic_top e2g_checker u_e2g_checker (.*);

@@ tb/sv/tb_ecef_to_geodetic_checker.sv @@
// checker for the ecef to geodetic block: mirrors the ellipsoid registers, predicts and compares
module tb_ecef_to_geodetic_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 busy,
   input  logic signed [e2g_pkg::COORD_W-1:0]   req_pos_x,
   input  logic signed [e2g_pkg::COORD_W-1:0]   req_pos_y,
   input  logic signed [e2g_pkg::COORD_W-1:0]   req_pos_z,
   input  logic                                 rsp_valid,
   input  logic signed [e2g_pkg::LAT_W-1:0]     rsp_latitude,
   input  logic signed [e2g_pkg::LON_W-1:0]     rsp_longitude,
   input  logic signed [e2g_pkg::HEIGHT_W-1:0]  rsp_height,
   input  logic                                 rsp_on_axis,
   input  logic                                 rsp_not_converged,
   input  logic                                 csr_we,
   input  logic [e2g_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [e2g_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output int                                   fail_count,
   output int                                   fixes_pending,
   output int                                   fixes_checked,
   output int                                   unconverged_seen
);
   import e2g_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [LAT_W-1:0]    latitude;
      logic [LON_W-1:0]    longitude;
      logic [HEIGHT_W-1:0] height;
      logic                on_axis;
      logic                not_converged;
   } geo_fix_t;

   typedef logic [63:0] arctan_rom_t [CORDIC_STEPS];

   logic [AXIS_W-1:0] semi_major;
   logic [ECC_W-1:0]  ecc1_sq;
   logic [ECC_W-1:0]  ecc2_sq;
   logic [AXIS_W-1:0] polar_radius;
   geo_fix_t          fix_queue[$];
   arctan_rom_t       arctan_rom;

   function automatic arctan_rom_t build_arctan_rom();
      arctan_rom_t rom;
      logic [63:0] acc;
      int ex;
      rom[0] = QUARTER_PI_Q60;
      for (int i = 1; i < CORDIC_STEPS; i++) begin
         acc = '0;
         for (int k = 0; k < 64; k++) begin
            ex = 64 - i * (2 * k + 1);
            if (ex >= 1) begin
               if (k % 2 == 1) begin
                  acc = acc - (64'd1 << ex) / 64'(2 * k + 1);
               end else begin
                  acc = acc + (64'd1 << ex) / 64'(2 * k + 1);
               end
            end
         end
         rom[i] = (acc + 64'd8) >> 4;
      end
      return rom;
   endfunction

   function automatic logic [63:0] floor_root(logic [127:0] n);
      logic [63:0] res;
      logic [63:0] cand;
      res = '0;
      for (int b = 63; b >= 0; b--) begin
         cand = res | (64'd1 << b);
         if ({64'd0, cand} * {64'd0, cand} <= n) begin
            res = cand;
         end
      end
      return res;
   endfunction

   // saturates when the quotient does not fit 64 bits
   function automatic logic [63:0] sat_quotient(logic [127:0] n, logic [63:0] d);
      logic [127:0] q;
      if (d == 0 || n[127:64] >= d) begin
         return '1;
      end
      q = n / {64'd0, d};
      return q[63:0];
   endfunction

   function automatic logic [63:0] scale_q62(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
   endfunction

   function automatic logic [63:0] magnitude(logic signed [63:0] v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic signed [63:0] quadrant_angle(logic [63:0] xm, logic [63:0] ym);
      logic signed [63:0] vx;
      logic signed [63:0] vy;
      logic signed [63:0] dx;
      logic signed [63:0] dy;
      logic signed [63:0] ang;
      if (ym == 0) begin
         return 0;
      end
      if (xm == 0) begin
         return HALF_PI_Q60;
      end
      while ((xm | ym) < NORM_LIMIT) begin
         xm = xm << 1;
         ym = ym << 1;
      end
      vx = xm;
      vy = ym;
      ang = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = vy >>> i;
         dy = vx >>> i;
         if (vy >= 0) begin
            vx = vx + dx;
            vy = vy - dy;
            ang = ang + signed'(arctan_rom[i]);
         end else begin
            vx = vx - dx;
            vy = vy + dy;
            ang = ang - signed'(arctan_rom[i]);
         end
      end
      if (ang < 0) begin
         ang = 0;
      end
      if (ang > HALF_PI_Q60) begin
         ang = HALF_PI_Q60;
      end
      return ang;
   endfunction

   function automatic geo_fix_t predict_fix(logic signed [COORD_W-1:0] px,
                                            logic signed [COORD_W-1:0] py,
                                            logic signed [COORD_W-1:0] pz);
      geo_fix_t fix;
      logic signed [63:0] x, y, z, lon, lat, w, wn, h;
      logic [63:0] ax, ay, aw, r, ce, rk, tol, term, dw, s, we, e, n, diff;
      logic [127:0] r2, kr2;
      logic done;
      x = px;
      y = py;
      z = pz;
      fix = '0;
      if (x == 0 && y == 0) begin
         fix.on_axis = 1'b1;
         return fix;
      end
      ax = magnitude(x);
      ay = magnitude(y);
      r2 = {64'd0, ax} * {64'd0, ax} + {64'd0, ay} * {64'd0, ay};
      r = floor_root(r2);
      if (x == 0) begin
         lon = y > 0 ? HALF_PI_Q60 : -HALF_PI_Q60;
      end else begin
         lon = quadrant_angle(ax, ay);
         if (x < 0) begin
            lon = PI_Q60 - lon;
         end
         if (y < 0) begin
            lon = -lon;
         end
      end
      // latitude pass on w = r*tan(B)
      ce = scale_q62(64'(polar_radius), 64'(ecc1_sq));
      rk = r + scale_q62(r, 64'(ecc2_sq));
      kr2 = {64'd0, r} * {64'd0, rk};
      tol = (r - 64'd1) / TOL_DIVISOR;
      w = z;
      done = 1'b0;
      for (int it = 0; it < MAX_ITERATIONS && !done; it++) begin
         aw = magnitude(w);
         term = sat_quotient({64'd0, ce} * {64'd0, aw},
                             floor_root(kr2 + {64'd0, aw} * {64'd0, aw}));
         wn = w < 0 ? z - signed'(term) : z + signed'(term);
         dw = magnitude(wn - w);
         w = wn;
         done = dw <= tol;
      end
      aw = magnitude(w);
      lat = quadrant_angle(r, aw);
      if (w < 0) begin
         lat = -lat;
      end
      s = floor_root(r2 + {64'd0, aw} * {64'd0, aw});
      we = aw - scale_q62(aw, 64'(ecc1_sq));
      e = floor_root(r2 + {64'd0, aw} * {64'd0, we});
      n = sat_quotient({64'd0, 64'(semi_major)} * {64'd0, s}, e);
      if (n > s) begin
         diff = n - s;
         h = diff > (64'd1 << 47) ? -(64'sd1 <<< 47) : -signed'(diff);
      end else begin
         diff = s - n;
         h = diff > ((64'd1 << 47) - 1) ? (64'sd1 <<< 47) - 1 : signed'(diff);
      end
      fix.latitude = lat[LAT_W-1:0];
      fix.longitude = lon[LON_W-1:0];
      fix.height = h[HEIGHT_W-1:0];
      fix.not_converged = !done;
      return fix;
   endfunction

   initial begin
      arctan_rom = build_arctan_rom();
      fail_count = 0;
      fixes_checked = 0;
      unconverged_seen = 0;
   end

   assign fixes_pending = fix_queue.size();

   always @(posedge clock) begin
      geo_fix_t got;
      geo_fix_t want;
      if (reset) begin
         semi_major <= SEMI_MAJOR_RESET;
         ecc1_sq <= FIRST_ECC_RESET;
         ecc2_sq <= SECOND_ECC_RESET;
         polar_radius <= POLAR_RADIUS_RESET;
         fix_queue.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SEMI_MAJOR: begin
                  semi_major <= csr_wdata[AXIS_W-1:0];
               end
               CSR_FIRST_ECC: begin
                  ecc1_sq <= csr_wdata[ECC_W-1:0];
               end
               CSR_SECOND_ECC: begin
                  ecc2_sq <= csr_wdata[ECC_W-1:0];
               end
               CSR_POLAR_RADIUS: begin
                  polar_radius <= csr_wdata[AXIS_W-1:0];
               end
               default: begin
               end
            endcase
         end
         if (start && !busy) begin
            fix_queue.push_back(predict_fix(req_pos_x, req_pos_y, req_pos_z));
         end
         if (rsp_valid) begin
            got = {rsp_latitude, rsp_longitude, rsp_height, rsp_on_axis, rsp_not_converged};
            if (fix_queue.size() == 0) begin
               fail_count <= fail_count + 1;
               $display("%0t: unexpected fix lat=%h lon=%h h=%h axis=%b nc=%b", $time,
                        got.latitude, got.longitude, got.height, got.on_axis,
                        got.not_converged);
            end else begin
               want = fix_queue.pop_front();
               fixes_checked <= fixes_checked + 1;
               if (want.not_converged) begin
                  unconverged_seen <= unconverged_seen + 1;
               end
               if (got !== want) begin
                  fail_count <= fail_count + 1;
                  $display("%0t: fix mismatch expected lat=%h lon=%h h=%h axis=%b nc=%b",
                           $time, want.latitude, want.longitude, want.height,
                           want.on_axis, want.not_converged);
                  $display("%0t:                actual lat=%h lon=%h h=%h axis=%b nc=%b",
                           $time, got.latitude, got.longitude, got.height,
                           got.on_axis, got.not_converged);
               end
            end
         end
      end
   end

endmodule

@@ tb/sv/tb_ecef_to_geodetic_top.sv @@
// testbench top of the ecef to geodetic block: clock, reset, stimulus and verdict
module tb_ecef_to_geodetic_top;
   import e2g_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // limit on the whole run, with room several times over for the worst fixes
   localparam longint CYCLE_LIMIT = 16_000_000;
   localparam int RANDOM_PER_PHASE = 205;
   // an index past the last register, which the block must ignore
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd5;
   localparam logic signed [COORD_W-1:0] COORD_MAX = 48'sh7fff_ffff_ffff;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 48'sh8000_0000_0000;
   localparam logic signed [COORD_W-1:0] EARTH_R = 48'sd417997586432;

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic signed [COORD_W-1:0]   req_pos_x;
   logic signed [COORD_W-1:0]   req_pos_y;
   logic signed [COORD_W-1:0]   req_pos_z;
   logic                        rsp_valid;
   logic signed [LAT_W-1:0]     rsp_latitude;
   logic signed [LON_W-1:0]     rsp_longitude;
   logic signed [HEIGHT_W-1:0]  rsp_height;
   logic                        rsp_on_axis;
   logic                        rsp_not_converged;
   logic                        csr_we;
   logic [CSR_IDX_W-1:0]        csr_index;
   logic [CSR_DATA_W-1:0]       csr_wdata;
   int                          fail_count;
   int                          fixes_pending;
   int                          fixes_checked;
   int                          unconverged_seen;
   longint                      cycle_count;
   int                          burst_left;
   int                          items_sent;
   int                          settings_used;

   ecef_to_geodetic_top i_dut (.*);

   tb_ecef_to_geodetic_checker i_checker (.*);

   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   // watchdog
   initial begin
      cycle_count = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_ecef_to_geodetic_top failed");
         $finish;
      end
   end

   // one position item; start stays high when the burst goes on
   task automatic send_position(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                                logic signed [COORD_W-1:0] z);
      start <= 1'b1;
      req_pos_x <= x;
      req_pos_y <= y;
      req_pos_z <= z;
      // busy only moves at rising edges, so a low value here means taken at the next one
      while (busy) begin
         @(negedge clock);
      end
      @(posedge clock);
      @(negedge clock);
      items_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 40)) @(negedge clock);
         // now and then a long burst with no idling at all
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 6);
      end
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   // drop start, let every fix come back, then allow for any on-axis tail
   task automatic drain_fixes();
      start <= 1'b0;
      @(negedge clock);
      while (busy || fixes_pending != 0) begin
         @(negedge clock);
      end
      repeat (10) @(negedge clock);
   endtask

   task automatic load_ellipsoid(logic [CSR_DATA_W-1:0] a, logic [CSR_DATA_W-1:0] e1,
                                 logic [CSR_DATA_W-1:0] e2, logic [CSR_DATA_W-1:0] c);
      drain_fixes();
      write_register(CSR_SEMI_MAJOR, a);
      write_register(CSR_FIRST_ECC, e1);
      write_register(CSR_SECOND_ECC, e2);
      write_register(CSR_POLAR_RADIUS, c);
      write_register(CSR_UNMAPPED, CSR_DATA_W'({$urandom, $urandom}));
      csr_we <= 1'b0;
      @(negedge clock);
      settings_used++;
   endtask

   function automatic logic signed [COORD_W-1:0] random_coord();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            return raw[COORD_W-1:0];
         end
         3, 4, 5, 6: begin
            // surface and orbit scale
            return COORD_W'(signed'(raw[40:0]));
         end
         7: begin
            return COORD_W'(signed'(raw[12:0]));
         end
         8: begin
            return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
         end
         default: begin
            return '0;
         end
      endcase
   endfunction

   task automatic random_positions(int count);
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      for (int i = 0; i < count; i++) begin
         x = random_coord();
         y = random_coord();
         // keep some items on the polar axis
         if ($urandom_range(0, 24) == 0) begin
            x = '0;
            y = '0;
         end
         send_position(x, y, random_coord());
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_pos_x = '0;
      req_pos_y = '0;
      req_pos_z = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      items_sent = 0;
      settings_used = 1;
      burst_left = 3;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset ellipsoid, axis, quadrants, poles and range ends
      send_position('0, '0, '0);
      send_position('0, '0, EARTH_R);
      send_position('0, '0, COORD_MIN);
      send_position(EARTH_R, '0, '0);
      send_position(-EARTH_R, '0, '0);
      send_position('0, EARTH_R, '0);
      send_position('0, -EARTH_R, '0);
      send_position('0, 48'sd1, '0);
      send_position('0, -48'sd1, 48'sd5);
      send_position(-48'sd1, '0, '0);
      send_position(48'sd1, 48'sd1, 48'sd1);
      send_position(EARTH_R, EARTH_R, EARTH_R);
      send_position(-EARTH_R, -EARTH_R, -EARTH_R);
      send_position(COORD_MAX, COORD_MAX, COORD_MAX);
      send_position(COORD_MIN, COORD_MIN, COORD_MIN);
      send_position(COORD_MIN, COORD_MAX, '0);
      send_position(COORD_MAX, COORD_MIN, COORD_MIN);
      send_position(48'sd3, '0, COORD_MAX);
      send_position(48'sd100, -48'sd7, EARTH_R);
      send_position(-EARTH_R, 48'sd12345, -48'sd99999);
      random_positions(RANDOM_PER_PHASE);

      // every register at zero
      load_ellipsoid('0, '0, '0, '0);
      send_position(EARTH_R, '0, EARTH_R);
      random_positions(RANDOM_PER_PHASE);

      // every register at full scale, with bits beyond the narrow registers set
      load_ellipsoid('1, '1, '1, '1);
      send_position(EARTH_R, '0, EARTH_R);
      random_positions(RANDOM_PER_PHASE);

      // random ellipsoid
      load_ellipsoid(CSR_DATA_W'({$urandom, $urandom}), CSR_DATA_W'({$urandom, $urandom}),
                     CSR_DATA_W'({$urandom, $urandom}), CSR_DATA_W'({$urandom, $urandom}));
      random_positions(RANDOM_PER_PHASE);

      // back to the earth ellipsoid
      load_ellipsoid(CSR_DATA_W'(SEMI_MAJOR_RESET), CSR_DATA_W'(FIRST_ECC_RESET),
                     CSR_DATA_W'(SECOND_ECC_RESET), CSR_DATA_W'(POLAR_RADIUS_RESET));
      random_positions(RANDOM_PER_PHASE);

      drain_fixes();
      $display("sent %0d positions over %0d ellipsoid settings, %0d fixes checked",
               items_sent, settings_used, fixes_checked);
      $display("%0d of the fixes ran out of latitude passes", unconverged_seen);
      if (fail_count == 0 && fixes_pending == 0) begin
         $display("tb_ecef_to_geodetic_top passed");
      end else begin
         $display("tb_ecef_to_geodetic_top failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hdl/e2g_pkg.sv
hdl/ecef_to_geodetic_top.sv
hdl/e2g_checker.sv
tb/sv/tb_ecef_to_geodetic_checker.sv
tb/sv/tb_ecef_to_geodetic_top.sv
